// File: rtl/ufr_pkg.sv
`default_nettype none

package ufr_pkg;

    // receiver phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_DATA   = 3'd2,
        PH_PARITY = 3'd3,
        PH_STOP   = 3'd4
    } phase_t;

    // frame status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FRAME  = 2'd1,
        ST_PARITY = 2'd2
    } frame_status_t;

    // parity modes
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_HALF_BIT_TICKS = 2'd0;
    localparam logic [1:0] REG_DATA_BIT_COUNT = 2'd1;
    localparam logic [1:0] REG_STOP_BIT_COUNT = 2'd2;
    localparam logic [1:0] REG_PARITY_MODE    = 2'd3;

    // register reset values
    localparam logic [15:0] HALF_BIT_TICKS_RST = 16'd1093;
    localparam logic [3:0]  DATA_BIT_COUNT_RST = 4'd8;
    localparam logic [1:0]  STOP_BIT_COUNT_RST = 2'd1;
    localparam logic [1:0]  PARITY_MODE_RST    = PAR_NONE;

    localparam int unsigned TICK_W = 17;
    localparam logic [3:0]  MIN_DATA_BITS = 4'd5;

endpackage : ufr_pkg

`default_nettype wire

// File: rtl/uart_frame_receiver.sv
`default_nettype none

// serial frame receiver, one line sample per input beat
// s_axis: one beat per oversampling tick, tdata[0] is the rx line level
// m_axis: one beat per finished frame, tdata[7:0] data byte (lsb first,
//   unused upper bits zero), tdata[9:8] status (0 ok, 1 framing, 2 parity)
// cfg: write channel, cfg_index selects half_bit_ticks, data_bit_count,
//   stop_bit_count or parity_mode; always ready, write only while idle
// path: a sample enters an input register, the frame state machine and
//   tick counter update in one pass, a result lands in the output register
// throughput: one sample per cycle while no result waits on m_axis, set by
//   the single-pass update of the tick counter and frame state
// stall: while a result waits on m_axis the held sample is not processed;
//   an empty input register still takes one more beat, then tready drops
// reset: configuration registers return to defaults, receiver waits for a start edge
module uart_frame_receiver #(
    parameter int unsigned MAX_DATA_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // rx_level
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    // received_byte [7:0], frame_status [9:8]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import ufr_pkg::*;

    localparam logic [3:0] MAX_BITS = 4'(MAX_DATA_BITS);

    // configuration registers
    logic [15:0] half_bit_ticks_reg;
    logic [3:0]  data_bit_count_reg;
    logic [1:0]  stop_bit_count_reg;
    logic [1:0]  parity_mode_reg;

    // input stage
    logic in_valid_reg;
    logic in_rx_reg;

    // frame state
    phase_t                    phase_reg, phase_next;
    logic [TICK_W-1:0]         tick_count_reg, tick_count_next;
    logic [3:0]                bit_index_reg, bit_index_next;
    logic [MAX_DATA_BITS-1:0]  shift_data_reg, shift_data_next;
    logic                      got_parity_reg, got_parity_next;
    logic [1:0]                stop_index_reg, stop_index_next;

    // output stage
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    frame_status_t out_status_reg;

    // single-pass results
    logic          fire;
    logic          res_valid;
    frame_status_t res_status;

    logic [15:0]       half_eff;
    logic [3:0]        data_bits_eff;
    logic [1:0]        stop_bits_eff;
    logic              parity_en;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] target;
    logic              reached;
    logic [3:0]        bit_index_inc;
    logic [1:0]        stop_index_inc;
    logic              parity_expect;

    // handshakes
    assign cfg_ready     = 1'b1;
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_status_reg, out_byte_reg};

    // effective settings
    assign half_eff      = (half_bit_ticks_reg == 16'd0) ? 16'd1 : half_bit_ticks_reg;
    assign data_bits_eff = (data_bit_count_reg < MIN_DATA_BITS) ? MIN_DATA_BITS :
                           (data_bit_count_reg > MAX_BITS) ? MAX_BITS : data_bit_count_reg;
    assign stop_bits_eff = (stop_bit_count_reg == 2'd0) ? 2'd1 :
                           (stop_bit_count_reg == 2'd3) ? 2'd2 : stop_bit_count_reg;
    assign parity_en     = (parity_mode_reg == PAR_EVEN) || (parity_mode_reg == PAR_ODD);

    // tick counting
    assign tick_inc       = tick_count_reg + TICK_W'(1);
    assign target         = (phase_reg == PH_START) ? {1'b0, half_eff} : {half_eff, 1'b0};
    assign reached        = tick_inc >= target;
    assign bit_index_inc  = bit_index_reg + 4'd1;
    assign stop_index_inc = stop_index_reg + 2'd1;
    assign parity_expect  = (^shift_data_reg) ^ (parity_mode_reg == PAR_ODD);

    // next frame state
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_data_next = shift_data_reg;
        got_parity_next = got_parity_reg;
        stop_index_next = stop_index_reg;
        if (phase_reg == PH_IDLE)
        begin
            if (!in_rx_reg)
            begin
                phase_next      = PH_START;
                tick_count_next = '0;
                bit_index_next  = '0;
                shift_data_next = '0;
                got_parity_next = 1'b0;
                stop_index_next = '0;
            end
        end
        else if (!reached)
        begin
            tick_count_next = tick_inc;
        end
        else
        begin
            tick_count_next = '0;
            case (phase_reg)
                PH_START:
                begin
                    phase_next = in_rx_reg ? PH_IDLE : PH_DATA;
                end
                PH_DATA:
                begin
                    for (int i = 0; i < MAX_DATA_BITS; i++)
                    begin
                        if (bit_index_reg == 4'(i))
                        begin
                            shift_data_next[i] = shift_data_reg[i] | in_rx_reg;
                        end
                    end
                    bit_index_next = bit_index_inc;
                    if (bit_index_inc >= data_bits_eff)
                    begin
                        phase_next = parity_en ? PH_PARITY : PH_STOP;
                    end
                end
                PH_PARITY:
                begin
                    got_parity_next = in_rx_reg;
                    phase_next      = PH_STOP;
                end
                PH_STOP:
                begin
                    if (!in_rx_reg)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        stop_index_next = stop_index_inc;
                        if (stop_index_inc >= stop_bits_eff)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result of this sample
    always_comb
    begin
        res_valid  = 1'b0;
        res_status = ST_OK;
        if (phase_reg != PH_IDLE && reached)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (in_rx_reg)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_FRAME;
                    end
                end
                PH_STOP:
                begin
                    if (!in_rx_reg)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_FRAME;
                    end
                    else if (stop_index_inc >= stop_bits_eff)
                    begin
                        res_valid  = 1'b1;
                        res_status = (parity_en && (parity_expect != got_parity_reg)) ?
                                     ST_PARITY : ST_OK;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_ticks_reg <= HALF_BIT_TICKS_RST;
            data_bit_count_reg <= DATA_BIT_COUNT_RST;
            stop_bit_count_reg <= STOP_BIT_COUNT_RST;
            parity_mode_reg    <= PARITY_MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HALF_BIT_TICKS: half_bit_ticks_reg <= cfg_data;
                REG_DATA_BIT_COUNT: data_bit_count_reg <= cfg_data[3:0];
                REG_STOP_BIT_COUNT: stop_bit_count_reg <= cfg_data[1:0];
                REG_PARITY_MODE:    parity_mode_reg    <= cfg_data[1:0];
                default:            parity_mode_reg    <= parity_mode_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_rx_reg    <= 1'b1;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            if (s_axis_tvalid)
            begin
                in_rx_reg <= s_axis_tdata[0];
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_data_reg <= '0;
            got_parity_reg <= 1'b0;
            stop_index_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_data_reg <= shift_data_next;
            got_parity_reg <= got_parity_next;
            stop_index_reg <= stop_index_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_byte_reg   <= 8'(shift_data_reg);
            out_status_reg <= res_status;
        end
    end

`ifndef SYNTH
    // idle receiver keeps its tick counter cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_count_reg == '0))
        else $error("tick counter running while idle");

    // every result closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid) |=> (phase_reg == PH_IDLE) && out_valid_reg)
        else $error("result without return to idle");

    // data bit index never passes the widest frame
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= MAX_BITS)
        else $error("data bit index out of range");

    // a held sample is not lost while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> in_valid_reg && $stable(in_rx_reg))
        else $error("held sample dropped");
`endif

endmodule : uart_frame_receiver

`default_nettype wire

// File: dv/uart_frame_receiver_tb.sv
`default_nettype none

module uart_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufr_pkg::*;

    localparam int unsigned MAX_BITS       = 8;
    localparam int unsigned CLK_HALF_NS    = 10;
    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned RANDOM_FORMATS = 2;
    localparam int unsigned RANDOM_EVENTS  = 3;
    localparam logic [15:0] LONG_HALF      = 16'd16;

    // parity code with no meaning of its own, behaves as no parity
    localparam logic [1:0] PAR_RESERVED = 2'd3;

    typedef struct packed {
        logic [7:0]    rbyte;
        frame_status_t status;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // rx_level [0], upper bits zero
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // received_byte [7:0], frame_status [9:8]
    logic [15:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_HALF_BIT_TICKS;
    logic [15:0] cfg_data = 16'h0000;

    // line format as last written
    logic [15:0] fmt_half   = HALF_BIT_TICKS_RST;
    logic [3:0]  fmt_bits   = DATA_BIT_COUNT_RST;
    logic [1:0]  fmt_stop   = STOP_BIT_COUNT_RST;
    logic [1:0]  fmt_parity = PARITY_MODE_RST;

    // receiver state tracked alongside the block
    phase_t      rx_phase   = PH_IDLE;
    logic [16:0] tick_cnt   = '0;
    logic [3:0]  bit_idx    = '0;
    logic [7:0]  shift_byte = '0;
    logic        par_bit    = 1'b0;
    logic [1:0]  stop_idx   = '0;

    frame_result_t expected_frames[$];
    frame_result_t want;

    bit          gap_en = 1'b1;
    bit          rx_stall_en = 1'b1;
    bit          offering = 1'b0;
    int unsigned hold_req = 0;
    int unsigned errors = 0;
    int unsigned samples_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned idle_cycles = 0;

    uart_frame_receiver #(
        .MAX_DATA_BITS(MAX_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // effective half period, zero behaves as one
    function automatic int unsigned half_ticks();
        return (fmt_half == 16'd0) ? 1 : 32'(fmt_half);
    endfunction

    // effective data bit count, clamped to 5..MAX_BITS
    function automatic int unsigned frame_bits();
        if (fmt_bits < MIN_DATA_BITS)
            return 32'(MIN_DATA_BITS);
        if (32'(fmt_bits) > MAX_BITS)
            return MAX_BITS;
        return 32'(fmt_bits);
    endfunction

    // effective stop bit count, clamped to 1..2
    function automatic int unsigned stop_bits();
        if (fmt_stop == 2'd0)
            return 1;
        if (fmt_stop == 2'd3)
            return 2;
        return 32'(fmt_stop);
    endfunction

    function automatic bit parity_enabled();
        return (fmt_parity == PAR_EVEN) || (fmt_parity == PAR_ODD);
    endfunction

    // advance the receiver by one line sample, returns 1 when a frame closes
    function automatic bit line_sample_step(input logic rx, output frame_result_t res);
        logic [16:0]   target;
        bit            done;
        frame_status_t st;
        logic          par_want;
        done = 1'b0;
        st = ST_OK;
        res.rbyte = '0;
        res.status = ST_OK;
        if (rx_phase == PH_IDLE)
        begin
            if (!rx)
            begin
                rx_phase = PH_START;
                tick_cnt = '0;
                bit_idx = '0;
                shift_byte = '0;
                par_bit = 1'b0;
                stop_idx = '0;
            end
            return 1'b0;
        end
        target = (rx_phase == PH_START) ? 17'(half_ticks()) : 17'(2 * half_ticks());
        tick_cnt = tick_cnt + 17'd1;
        if (tick_cnt < target)
            return 1'b0;
        tick_cnt = '0;
        case (rx_phase)
            PH_START:
            begin
                if (rx)
                begin
                    done = 1'b1;
                    st = ST_FRAME;
                end
                else
                    rx_phase = PH_DATA;
            end
            PH_DATA:
            begin
                shift_byte = shift_byte | (8'(rx) << bit_idx[2:0]);
                bit_idx = bit_idx + 4'd1;
                if (32'(bit_idx) >= frame_bits())
                    rx_phase = parity_enabled() ? PH_PARITY : PH_STOP;
            end
            PH_PARITY:
            begin
                par_bit = rx;
                rx_phase = PH_STOP;
            end
            PH_STOP:
            begin
                if (!rx)
                begin
                    done = 1'b1;
                    st = ST_FRAME;
                end
                else
                begin
                    stop_idx = stop_idx + 2'd1;
                    if (32'(stop_idx) >= stop_bits())
                    begin
                        done = 1'b1;
                        if (parity_enabled())
                        begin
                            par_want = (^shift_byte) ^ (fmt_parity == PAR_ODD);
                            if (par_want != par_bit)
                                st = ST_PARITY;
                        end
                    end
                end
            end
            default:
            begin
                rx_phase = PH_IDLE;
                tick_cnt = '0;
            end
        endcase
        if (done)
        begin
            res.rbyte = shift_byte;
            res.status = st;
            rx_phase = PH_IDLE;
        end
        return done;
    endfunction

    // offer one line sample, with an occasional gap before it
    task automatic send_sample(input logic rx);
        frame_result_t res;
        if (gap_en && $urandom_range(0, 11) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, rx};
        offering = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        samples_sent++;
        if (line_sample_step(rx, res))
            expected_frames.push_back(res);
    endtask

    task automatic send_level(input logic rx, input int unsigned count);
        for (int i = 0; i < count; i++)
            send_sample(rx);
    endtask

    // one frame in the current format, optionally broken
    task automatic send_frame(input logic [7:0] data, input bit flip_par, input bit bad_stop,
                              input bit glitch);
        int unsigned h;
        int unsigned nb;
        int unsigned ns;
        logic        par;
        h = half_ticks();
        nb = frame_bits();
        ns = stop_bits();
        send_level(1'b1, $urandom_range(1, 3));
        if (glitch)
        begin
            // start bit gone high again by mid-bit
            send_level(1'b0, $urandom_range(1, h));
            send_level(1'b1, 2 * h);
        end
        else
        begin
            send_level(1'b0, 2 * h);
            par = (fmt_parity == PAR_ODD) ^ flip_par;
            for (int i = 0; i < nb; i++)
            begin
                send_level(data[i], 2 * h);
                par ^= data[i];
            end
            if (parity_enabled())
                send_level(par, 2 * h);
            for (int s = 0; s < ns; s++)
            begin
                // a bad stop bit is low only up to its sample point
                if (bad_stop && s == ns - 1)
                    send_level(1'b0, h + 1);
                else
                    send_level(1'b1, 2 * h);
            end
        end
    endtask

    // stop offering and wait for every outstanding frame
    task automatic pause_until_empty();
        if (offering)
        begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_frames.size() != 0)
            @(posedge clk);
    endtask

    // close any open frame, collect results, let the pipeline empty
    task automatic drain_to_idle();
        while (rx_phase != PH_IDLE)
            send_sample(1'b1);
        pause_until_empty();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register beat; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_writes++;
        case (idx)
            REG_HALF_BIT_TICKS: fmt_half = value;
            REG_DATA_BIT_COUNT: fmt_bits = value[3:0];
            REG_STOP_BIT_COUNT: fmt_stop = value[1:0];
            REG_PARITY_MODE:    fmt_parity = value[1:0];
            default: ;
        endcase
    endtask

    task automatic set_format(input logic [15:0] half, input logic [15:0] bits,
                              input logic [15:0] stops, input logic [15:0] par);
        drain_to_idle();
        write_reg(REG_HALF_BIT_TICKS, half);
        write_reg(REG_DATA_BIT_COUNT, bits);
        write_reg(REG_STOP_BIT_COUNT, stops);
        write_reg(REG_PARITY_MODE, par);
        cfg_valid <= 1'b0;
    endtask

    // reset values of bit count, stop bits and parity, with a short bit period
    task automatic test_reset_defaults();
        write_reg(REG_HALF_BIT_TICKS, 16'd1);
        cfg_valid <= 1'b0;
        send_frame(8'hA5, 1'b0, 1'b0, 1'b0);
        send_frame(8'($urandom), 1'b0, 1'b0, 1'b1);
    endtask

    // each status, byte extremes and every out-of-range register code
    task automatic test_line_formats();
        set_format(16'd0, 16'd8, 16'd1, 16'(PAR_NONE));
        send_frame(8'h00, 1'b0, 1'b0, 1'b0);
        send_frame(8'hFF, 1'b0, 1'b0, 1'b0);
        send_frame(8'h00, 1'b0, 1'b0, 1'b1);
        send_frame(8'h96, 1'b0, 1'b1, 1'b0);
        set_format(16'd1, 16'd8, 16'd1, 16'(PAR_EVEN));
        send_frame(8'h5A, 1'b0, 1'b0, 1'b0);
        send_frame(8'h5B, 1'b1, 1'b0, 1'b0);
        set_format(16'd1, 16'd8, 16'd1, 16'(PAR_ODD));
        send_frame(8'h3C, 1'b0, 1'b0, 1'b0);
        send_frame(8'h3C, 1'b1, 1'b0, 1'b0);
        set_format(16'd1, 16'd8, 16'd1, 16'(PAR_RESERVED));
        send_frame(8'h81, 1'b0, 1'b0, 1'b0);
        set_format(16'd1, 16'd4, 16'd2, 16'(PAR_NONE));
        send_frame(8'h1F, 1'b0, 1'b0, 1'b0);
        send_frame(8'h0A, 1'b0, 1'b1, 1'b0);
        set_format(16'd1, 16'd15, 16'd0, 16'(PAR_EVEN));
        send_frame(8'hFF, 1'b0, 1'b0, 1'b0);
        set_format(16'd1, 16'd5, 16'd3, 16'(PAR_ODD));
        send_frame(8'h15, 1'b0, 1'b0, 1'b0);
        send_frame(8'h0E, 1'b0, 1'b1, 1'b0);
        set_format(16'd2, 16'd0, 16'd2, 16'(PAR_EVEN));
        send_frame(8'h0A, 1'b1, 1'b0, 1'b0);
    endtask

    // longer half period, start bit rejected at its sample point
    task automatic test_long_half_period();
        set_format(LONG_HALF, 16'd5, 16'd1, 16'(PAR_NONE));
        send_level(1'b1, 2);
        send_level(1'b0, $urandom_range(1, LONG_HALF / 2));
        send_level(1'b1, 2 * LONG_HALF);
    endtask

    // random formats, mostly clean frames with random content
    task automatic test_random_frames();
        int unsigned kind;
        int unsigned noise_len;
        logic [15:0] half;
        logic [3:0]  bits;
        for (int f = 0; f < RANDOM_FORMATS; f++)
        begin
            half = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'd1;
            bits = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(5, 8));
            set_format(half, {12'($urandom), bits}, {14'($urandom), 2'($urandom)},
                       {14'($urandom), 2'($urandom)});
            for (int n = 0; n < RANDOM_EVENTS; n++)
            begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0: send_frame(8'($urandom), 1'b0, 1'b0, 1'b1);
                    1: send_frame(8'($urandom), 1'b0, 1'b1, 1'b0);
                    2: send_frame(8'($urandom), 1'b1, 1'b0, 1'b0);
                    3:
                    begin
                        noise_len = $urandom_range(1, 8);
                        for (int i = 0; i < noise_len; i++)
                            send_sample(1'($urandom));
                    end
                    default: send_frame(8'($urandom), 1'b0, 1'b0, 1'b0);
                endcase
            end
        end
    endtask

    // sender stalls behind a result held through a long receiver hold-off
    task automatic test_output_hold();
        set_format(16'd1, 16'd8, 16'd1, 16'(PAR_NONE));
        hold_req = HOLD_CYCLES;
        repeat (3) send_frame(8'($urandom), 1'b0, 1'b0, 1'b0);
    endtask

    // sender waits for every result after each frame
    task automatic test_sender_pause();
        set_format(16'd1, 16'd7, 16'd2, 16'(PAR_EVEN));
        repeat (2)
        begin
            send_frame(8'($urandom), 1'($urandom), 1'b0, 1'b0);
            pause_until_empty();
        end
    endtask

    // back-to-back beats on both sides
    task automatic test_no_idling();
        gap_en = 1'b0;
        rx_stall_en = 1'b0;
        set_format(16'd1, 16'd6, 16'd1, 16'(PAR_ODD));
        repeat (3)
            send_frame(8'($urandom), 1'($urandom), ($urandom_range(0, 3) == 0), 1'b0);
    endtask

    // result side: random stall bursts and the long hold-off
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req != 0)
            begin
                stall_left = hold_req - 1;
                hold_req = 0;
                m_axis_tready <= 1'b0;
            end
            else if (rx_stall_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // compare each result beat with the oldest expected frame
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_frames.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected, expected nothing, actual 0x%04h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (m_axis_tdata[7:0] !== want.rbyte)
                begin
                    errors++;
                    $display("%0t: received_byte mismatch, expected 0x%02h, actual 0x%02h",
                             $time, want.rbyte, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[9:8] !== want.status)
                begin
                    errors++;
                    $display("%0t: frame_status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_axis_tdata[9:8]);
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no beat for %0d cycles, %0d frames outstanding",
                         $time, idle_cycles, expected_frames.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_line_formats();
        test_long_half_period();
        test_random_frames();
        test_output_hold();
        test_sender_pause();
        test_no_idling();
        drain_to_idle();
        $display("Covered %0d line samples, %0d result beats, %0d register writes",
                 samples_sent, results_seen, cfg_writes);
        $display("  short and long bit periods, every bit count, stop and parity code");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule : uart_frame_receiver_tb

`default_nettype wire

// File: sim.f
rtl/ufr_pkg.sv
rtl/uart_frame_receiver.sv
dv/uart_frame_receiver_tb.sv
